### src/cau_pkg.sv
package cau_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_EQ   = 3'd4;
	localparam logic [2:0] OP_CONJ = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [63:0] DIV_ZERO_LIMIT = 64'd4;
	localparam int QW = 33;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
	} in_t;

	typedef struct packed {
		logic signed [31:0] res_real;
		logic signed [31:0] res_imag;
		logic               is_equal;
		logic [1:0]         status;
	} out_t;

	typedef struct packed {
		logic [2:0]      op;
		out_t            res;
		logic            dz;
		logic            big_r;
		logic            big_i;
		logic            neg_r;
		logic            neg_i;
		logic [63:0]     d;
		logic [63:0]     rem_r;
		logic [63:0]     rem_i;
		logic [QW-1:0]   x_r;
		logic [QW-1:0]   x_i;
		logic [QW-1:0]   q_r;
		logic [QW-1:0]   q_i;
	} dv_t;

	function automatic logic signed [48:0] sx49(input logic [31:0] v);
		return $signed({{17{v[31]}}, v});
	endfunction

	// {saturated, value}
	function automatic logic [32:0] sat49(input logic signed [48:0] v);
		if (v > $signed(49'h0_0000_7FFF_FFFF))
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < $signed(49'h1_FFFF_8000_0000))
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

endpackage

### src/cau_front.sv
module cau_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   tol,
	input  logic          in_valid,
	output logic          in_stall,
	input  cau_pkg::in_t  in_item,
	output logic          dv_valid,
	output cau_pkg::dv_t  dv_data,
	input  logic          down_en
);
	import cau_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	in_t                in_s1;
	logic [2:0]         op_s2, op_s3, op_s4;
	out_t               res_s2, res_s3, res_s4;
	logic signed [63:0] prr_s2, pii_s2, pri_s2, pir_s2;
	logic [63:0]        pbr_s2, pbi_s2;
	logic signed [64:0] nr_s3, ni_s3;
	logic [63:0]        d_s3, d_s4;
	logic               neg_r_s4, neg_i_s4, dz_s4;
	logic [63:0]        mag_r_s4, mag_i_s4;
	dv_t                dv_s5;

	assign en5 = !v_s5 || down_en;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// simple ops from stage 1
	logic signed [48:0] sr, si, dr, di, tl;
	logic [32:0]        satr, sati;
	logic               eqv;

	always_comb begin
		sr = '0;
		si = '0;
		eqv = 1'b0;
		tl = $signed({33'b0, tol});
		dr = sx49(in_s1.a_real) - sx49(in_s1.b_real);
		di = sx49(in_s1.a_imag) - sx49(in_s1.b_imag);
		case (in_s1.req_type)
			OP_ADD: begin
				sr = sx49(in_s1.a_real) + sx49(in_s1.b_real);
				si = sx49(in_s1.a_imag) + sx49(in_s1.b_imag);
			end
			OP_SUB: begin
				sr = dr;
				si = di;
			end
			OP_CONJ: begin
				sr = sx49(in_s1.a_real);
				si = -sx49(in_s1.a_imag);
			end
			OP_EQ: begin
				eqv = (dr <= tl) && (dr >= -tl) && (di <= tl) && (di >= -tl);
			end
			default: begin
				sr = '0;
			end
		endcase
		satr = sat49(sr);
		sati = sat49(si);
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) in_s1 <= in_item;
		if (en2) begin
			op_s2 <= in_s1.req_type;
			res_s2.res_real <= satr[31:0];
			res_s2.res_imag <= sati[31:0];
			res_s2.is_equal <= eqv;
			res_s2.status <= (satr[32] || sati[32]) ? ST_SAT : ST_OK;
			prr_s2 <= $signed(in_s1.a_real) * $signed(in_s1.b_real);
			pii_s2 <= $signed(in_s1.a_imag) * $signed(in_s1.b_imag);
			pri_s2 <= $signed(in_s1.a_real) * $signed(in_s1.b_imag);
			pir_s2 <= $signed(in_s1.a_imag) * $signed(in_s1.b_real);
			pbr_s2 <= $signed(in_s1.b_real) * $signed(in_s1.b_real);
			pbi_s2 <= $signed(in_s1.b_imag) * $signed(in_s1.b_imag);
		end
	end

	// product sums
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3 <= op_s2;
			res_s3 <= res_s2;
			if (op_s2 == OP_MUL) begin
				nr_s3 <= {prr_s2[63], prr_s2} - {pii_s2[63], pii_s2};
				ni_s3 <= {pri_s2[63], pri_s2} + {pir_s2[63], pir_s2};
			end else begin
				nr_s3 <= {prr_s2[63], prr_s2} + {pii_s2[63], pii_s2};
				ni_s3 <= {pir_s2[63], pir_s2} - {pri_s2[63], pri_s2};
			end
			d_s3 <= pbr_s2 + pbi_s2;
		end
	end

	// multiply finish, divide operand magnitudes
	logic [32:0]        mr, mi;
	logic signed [64:0] ar, ai;
	out_t               res_m;

	always_comb begin
		mr = sat49($signed(nr_s3[64:16]));
		mi = sat49($signed(ni_s3[64:16]));
		ar = nr_s3[64] ? -nr_s3 : nr_s3;
		ai = ni_s3[64] ? -ni_s3 : ni_s3;
		res_m = res_s3;
		if (op_s3 == OP_MUL) begin
			res_m.res_real = mr[31:0];
			res_m.res_imag = mi[31:0];
			res_m.status = (mr[32] || mi[32]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			op_s4 <= op_s3;
			res_s4 <= res_m;
			neg_r_s4 <= nr_s3[64];
			neg_i_s4 <= ni_s3[64];
			mag_r_s4 <= ar[63:0];
			mag_i_s4 <= ai[63:0];
			d_s4 <= d_s3;
			dz_s4 <= d_s3 <= DIV_ZERO_LIMIT;
		end
	end

	// divider setup
	always_ff @(posedge clk) begin
		if (en5) begin
			dv_s5.op <= op_s4;
			dv_s5.res <= res_s4;
			dv_s5.dz <= dz_s4;
			dv_s5.d <= d_s4;
			dv_s5.neg_r <= neg_r_s4;
			dv_s5.neg_i <= neg_i_s4;
			dv_s5.big_r <= {17'b0, mag_r_s4[63:17]} >= d_s4;
			dv_s5.big_i <= {17'b0, mag_i_s4[63:17]} >= d_s4;
			dv_s5.rem_r <= {17'b0, mag_r_s4[63:17]};
			dv_s5.rem_i <= {17'b0, mag_i_s4[63:17]};
			dv_s5.x_r <= {mag_r_s4[16:0], 16'b0};
			dv_s5.x_i <= {mag_i_s4[16:0], 16'b0};
			dv_s5.q_r <= '0;
			dv_s5.q_i <= '0;
		end
	end

	assign dv_valid = v_s5;
	assign dv_data = dv_s5;

endmodule

### src/cau_divider.sv
module cau_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  cau_pkg::dv_t  in_data,
	output logic          up_en,
	output logic          out_valid,
	output cau_pkg::dv_t  out_data,
	input  logic          down_en
);
	import cau_pkg::*;

	logic v [QW];
	logic en [QW];
	dv_t  s [QW];

	// {qbit, remainder}
	function automatic logic [64:0] lane(input logic [63:0] rem, input logic b,
			input logic [63:0] d);
		logic [64:0] r, t;
		r = {rem, b};
		t = r - {1'b0, d};
		if (!t[64])
			return {1'b1, t[63:0]};
		else
			return {1'b0, r[63:0]};
	endfunction

	function automatic dv_t step(input dv_t x);
		dv_t         y;
		logic [64:0] lr, li;
		y = x;
		lr = lane(x.rem_r, x.x_r[QW-1], x.d);
		li = lane(x.rem_i, x.x_i[QW-1], x.d);
		y.rem_r = lr[63:0];
		y.rem_i = li[63:0];
		y.q_r = {x.q_r[QW-2:0], lr[64]};
		y.q_i = {x.q_i[QW-2:0], li[64]};
		y.x_r = {x.x_r[QW-2:0], 1'b0};
		y.x_i = {x.x_i[QW-2:0], 1'b0};
		return y;
	endfunction

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic pv;
		dv_t  pd;
		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign pd = in_data;
		end else begin : g_next
			assign pv = v[k-1];
			assign pd = s[k-1];
		end
		if (k == QW - 1) begin : g_last
			assign en[k] = !v[k] || down_en;
		end else begin : g_mid
			assign en[k] = !v[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v[k] <= 1'b0;
			else if (en[k])
				v[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en[k]) s[k] <= step(pd);
		end
	end

	assign up_en = en[0];
	assign out_valid = v[QW-1];
	assign out_data = s[QW-1];

endmodule

### src/cau_back.sv
module cau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          dv_valid,
	input  cau_pkg::dv_t  dv_data,
	output logic          up_en,
	output logic          out_valid,
	input  logic          out_stall,
	output cau_pkg::out_t out_item
);
	import cau_pkg::*;

	// {saturated, value}
	function automatic logic [32:0] fin(input logic [QW-1:0] q, input logic neg,
			input logic big);
		logic [QW-1:0] nq;
		nq = ~q + 1'b1;
		if (big)
			return {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
		else if (neg)
			return (q > 33'h0_8000_0000) ? {1'b1, 32'h8000_0000} : {1'b0, nq[31:0]};
		else
			return (q > 33'h0_7FFF_FFFF) ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
	endfunction

	logic [32:0] fr, fi;
	out_t        res;

	always_comb begin
		fr = fin(dv_data.q_r, dv_data.neg_r, dv_data.big_r);
		fi = fin(dv_data.q_i, dv_data.neg_i, dv_data.big_i);
		res = dv_data.res;
		if (dv_data.op == OP_DIV) begin
			res.is_equal = 1'b0;
			if (dv_data.dz) begin
				res.res_real = '0;
				res.res_imag = '0;
				res.status = ST_DIVZ;
			end else begin
				res.res_real = fr[31:0];
				res.res_imag = fi[31:0];
				res.status = (fr[32] || fi[32]) ? ST_SAT : ST_OK;
			end
		end
	end

	assign up_en = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (up_en)
			out_valid <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (up_en && dv_valid) out_item <= res;
	end

endmodule

### src/complex_arithmetic_unit_core.sv
// throughput: one item per cycle while the output is not stalled, through the 33-stage pipelined restoring divider
// a stalled output holds the pipeline; empty stages still fill behind it
// reset: arst_n clears all valid bits and sets the equality tolerance to zero
module complex_arithmetic_unit_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	input  logic          in_valid,
	output logic          in_stall,
	input  cau_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_stall,
	output cau_pkg::out_t out_item
);
	import cau_pkg::*;

	logic [15:0] tol_q;
	logic        f_valid, f_en, d_valid, d_en;
	dv_t         f_data, d_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= '0;
		else if (cfg_we)
			tol_q <= cfg_data;
	end

	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tol      (tol_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.dv_valid (f_valid),
		.dv_data  (f_data),
		.down_en  (f_en)
	);

	cau_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_data   (f_data),
		.up_en     (f_en),
		.out_valid (d_valid),
		.out_data  (d_data),
		.down_en   (d_en)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dv_valid  (d_valid),
		.dv_data   (d_data),
		.up_en     (d_en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

### src/cau_checker.sv
module cau_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_stall,
	input cau_pkg::out_t out_item
);
	import cau_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output changed under stall");

	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_DIVZ |->
		out_item.res_real == 0 && out_item.res_imag == 0 && !out_item.is_equal)
		else $error("divide by zero result not cleared");

	a_eq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_equal |->
		out_item.status == ST_OK && out_item.res_real == 0 && out_item.res_imag == 0)
		else $error("compare result carries data");

	a_st: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status == ST_OK || out_item.status == ST_DIVZ ||
		out_item.status == ST_SAT)
		else $error("bad status code");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

### verif/complex_arithmetic_unit_core_test.sv
`timescale 1ns / 1ps

module complex_arithmetic_unit_core_test;
	import cau_pkg::*;

	localparam int DRAIN_CYCLES = 45;

	typedef struct {
		in_t  item;
		bit   typed;
		out_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_item;

	logic [15:0] tolerance = '0;
	out_t expected_results[$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	dir_row_t dir_rows[] = '{
		'{'{OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF},
			1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, ST_SAT}},
		'{'{OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000},
			1'b1, '{32'h0004_0000, 32'h0001_0000, 1'b0, ST_OK}},
		'{'{OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF},
			1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, ST_SAT}},
		'{'{OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000},
			1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, ST_SAT}},
		'{'{OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000},
			1'b0, '0},
		'{'{OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			1'b0, '0},
		'{'{OP_MUL, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000},
			1'b0, '0},
		'{'{OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			1'b0, '0},
		'{'{OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_DIVZ}},
		'{'{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0002, 32'h0000_0000},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_DIVZ}},
		'{'{OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_DIVZ}},
		'{'{OP_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0000_0002, 32'h0000_0001},
			1'b0, '0},
		'{'{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0003, 32'h0000_0000},
			1'b0, '0},
		'{'{OP_DIV, 32'h0006_0000, 32'hFFFD_0000, 32'h0002_0000, 32'h0001_0000},
			1'b0, '0},
		'{'{OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			1'b0, '0},
		'{'{OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000},
			1'b1, '{32'h0, 32'h0, 1'b1, ST_OK}},
		'{'{OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5679, 32'h8000_0000},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_OK}},
		'{'{OP_EQ, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_OK}},
		'{'{OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0},
			1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, ST_SAT}},
		'{'{OP_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			1'b1, '{32'h7FFF_FFFF, 32'h8000_0001, 1'b0, ST_OK}},
		'{'{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_OK}},
		'{'{3'd7, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
			1'b1, '{32'h0, 32'h0, 1'b0, ST_OK}}
	};

	complex_arithmetic_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	// {saturated, value}
	function automatic logic [32:0] clamp32(input logic signed [81:0] v);
		if (v > 82'sh7FFF_FFFF)
			return {1'b1, 32'h7FFF_FFFF};
		else if (v < -82'sh8000_0000)
			return {1'b1, 32'h8000_0000};
		else
			return {1'b0, v[31:0]};
	endfunction

	function automatic logic signed [81:0] quotient(input logic signed [65:0] num,
			input logic [65:0] den);
		logic [65:0] mag;
		logic [81:0] q;
		mag = num < 0 ? -num : num;
		q = {mag, 16'b0} / {16'b0, den};
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic out_t complex_result(input in_t x, input logic [15:0] tol);
		logic signed [65:0] ar, ai, br, bi, pr, pi;
		logic [65:0] d;
		logic [32:0] cr, ci;
		out_t r;
		ar = x.a_real;
		ai = x.a_imag;
		br = x.b_real;
		bi = x.b_imag;
		r = '0;
		cr = '0;
		ci = '0;
		case (x.req_type)
			OP_ADD: begin
				cr = clamp32(ar + br);
				ci = clamp32(ai + bi);
			end
			OP_SUB: begin
				cr = clamp32(ar - br);
				ci = clamp32(ai - bi);
			end
			OP_MUL: begin
				pr = ar * br - ai * bi;
				pi = ar * bi + ai * br;
				cr = clamp32(pr >>> 16);
				ci = clamp32(pi >>> 16);
			end
			OP_DIV: begin
				d = br * br + bi * bi;
				if (d <= DIV_ZERO_LIMIT) begin
					r.status = ST_DIVZ;
				end else begin
					cr = clamp32(quotient(ar * br + ai * bi, d));
					ci = clamp32(quotient(ai * br - ar * bi, d));
				end
			end
			OP_EQ: begin
				pr = ar - br;
				pi = ai - bi;
				if (pr < 0) pr = -pr;
				if (pi < 0) pi = -pi;
				r.is_equal = (pr <= tol) && (pi <= tol);
			end
			OP_CONJ: begin
				cr = {1'b0, x.a_real};
				ci = clamp32(-ai);
			end
			default: ;
		endcase
		r.res_real = cr[31:0];
		r.res_imag = ci[31:0];
		if (r.status == ST_OK && (cr[32] || ci[32]))
			r.status = ST_SAT;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_transfer(input in_t x, input bit typed, input out_t res);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item <= x;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(typed ? res : complex_result(x, tolerance));
	endtask

	task automatic wait_idle();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tolerance = v;
	endtask

	function automatic logic [31:0] operand(input logic [31:0] near, input bit pick_near);
		case ($urandom_range(5))
			0: return pick_near ? near + $urandom_range(4) - 2 : $urandom;
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return $signed($urandom_range(16'hFFFF)) - 32'sh8000;
			3: return $signed($urandom_range(24'hFF_FFFF)) - 32'sh80_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t random_item();
		in_t x;
		x.req_type = $urandom_range(19) == 0 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
		x.a_real = operand(32'h0, 1'b0);
		x.a_imag = operand(32'h0, 1'b0);
		x.b_real = operand(x.a_real, x.req_type == OP_EQ);
		x.b_imag = operand(x.a_imag, x.req_type == OP_EQ);
		if (x.req_type == OP_EQ && $urandom_range(1)) begin
			x.b_real = x.a_real + $urandom_range(2 * tolerance + 2) - tolerance - 1;
			x.b_imag = x.a_imag + $urandom_range(2 * tolerance + 2) - tolerance - 1;
		end
		if (x.req_type == OP_DIV && $urandom_range(7) == 0) begin
			x.b_real = $signed($urandom_range(4)) - 2;
			x.b_imag = $signed($urandom_range(4)) - 2;
		end
		return x;
	endfunction

	// result checking
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report("output transfer with nothing expected");
			end else begin
				want = expected_results.pop_front();
				if (out_item.res_real !== want.res_real)
					report($sformatf("res_real %h, want %h", out_item.res_real, want.res_real));
				if (out_item.res_imag !== want.res_imag)
					report($sformatf("res_imag %h, want %h", out_item.res_imag, want.res_imag));
				if (out_item.is_equal !== want.is_equal)
					report($sformatf("is_equal %b, want %b", out_item.is_equal, want.is_equal));
				if (out_item.status !== want.status)
					report($sformatf("status %0d, want %0d", out_item.status, want.status));
			end
		end
	end

	always @(negedge clk)
		out_stall <= $urandom_range(99) < receiver_stall_pct;

	initial begin
		#20_000_000;
		$display("** complex_arithmetic_unit_core: FAILED **");
		$finish;
	end

	initial begin
		int idle_pcts[4];
		int stall_pcts[4];
		logic [15:0] tols[4];
		idle_pcts = '{0, 77, 0, 28};
		stall_pcts = '{0, 0, 77, 28};
		tols = '{16'hFFFF, 16'($urandom), 16'd1, 16'd0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (dir_rows[i])
			send_transfer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
		@(negedge clk);
		in_valid <= 1'b0;
		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(tols[ph]);
			sender_idle_pct = idle_pcts[ph];
			receiver_stall_pct = stall_pcts[ph];
			for (int n = 0; n < 108; n++)
				send_transfer(random_item(), 1'b0, '0);
			@(negedge clk);
			in_valid <= 1'b0;
		end
		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** complex_arithmetic_unit_core: PASSED **");
		else
			$display("** complex_arithmetic_unit_core: FAILED **");
		$finish;
	end

endmodule
